### design/slxfr_pkg.sv
package slxfr_pkg;

	// Field widths of the stream items
	localparam int BYTE_W   = 8;
	localparam int INDEX_W  = 9;
	localparam int STATUS_W = 3;
	localparam int LEN_W    = 16;
	localparam int OUT_W    = 24;

	// Configuration register indexes and reset values
	localparam int CFG_ADDR_W = 1;
	localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_FIRST  = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_SECOND = 1'd1;
	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h4C;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h54;

	// Header layout: prefix checksum entries for indexes 0..5, length check at 6
	localparam int PREFIX_DEPTH = 6;
	localparam int PREFIX_AW    = 3;
	localparam int LEN_CHECK_POS = 6;

	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_SYNC1 = 2'd1,
		PH_BODY  = 2'd2
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_PROGRESS = 3'd0,
		ST_FRAME_OK = 3'd1,
		ST_LEN_BIG  = 3'd2,
		ST_XOR_BAD  = 3'd3,
		ST_BAD_SYNC = 3'd4,
		ST_OVERFLOW = 3'd5
	} status_t;

	typedef struct packed {
		status_t                status;
		logic                   in_frame;
		logic [INDEX_W-1:0]     byte_index;
		logic [BYTE_W-1:0]      data_byte;
	} result_t;

endpackage

### design/sync_length_xor_frame_receiver.sv
// Frame receiver: sync pair, big-endian length in bytes 3 and 4, XOR checksum.
// Input channel s_*: one received byte per item (s_tdata[7:0] = rx_byte).
// Output channel m_*: exactly one result item per input item, in order.
//   Each byte is echoed with its frame index, an in-frame flag and a status
//   (progress, frame ok, length too large, xor mismatch, bad sync, overflow).
// Config port: cfg_we/cfg_addr/cfg_wdata writes sync_first (0) or sync_second (1);
//   write only while no item is in flight.
// Path: a byte accepted is held in the input register, then the frame logic writes its
//   result into the result register.
// Throughput: one item per cycle unless m_tready stalls; one frame-state step per byte,
//   so the per-byte compare/XOR path into the result register sets the rate.
// Stall: when m_tready is low the result register holds and one more byte is
//   kept in the input register; s_tready drops only when both are full.
// Reset: arst_n clears the pipeline valids, returns to sync hunting and restores
//   the sync bytes to 0x4C and 0x54.
module sync_length_xor_frame_receiver #(
	parameter int MAX_LEN = 512
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// s_tdata: rx_byte[7:0]
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [slxfr_pkg::BYTE_W-1:0]        s_tdata,
	// m_tdata: data_byte[7:0], byte_index[16:8], in_frame[17], status[20:18], zero[23:21]
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [slxfr_pkg::OUT_W-1:0]         m_tdata,
	input  logic                                cfg_we,
	input  logic [slxfr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [slxfr_pkg::BYTE_W-1:0]        cfg_wdata
);
	import slxfr_pkg::*;

	localparam int PW = $clog2(MAX_LEN + 1);
	localparam logic [PW-1:0] LAST_POS = PW'(MAX_LEN - 1);
	localparam logic [LEN_W-1:0] MAX_LEN_C = LEN_W'(MAX_LEN);

	// Configuration registers
	logic [BYTE_W-1:0] sync_first_q, sync_second_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_SYNC_FIRST:  sync_first_q  <= cfg_wdata;
				CFG_SYNC_SECOND: sync_second_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Pipeline control
	logic              valid_s1, out_valid_q;
	logic [BYTE_W-1:0] byte_s1;
	logic              adv;

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// Frame state
	phase_t            phase_q, phase_n;
	logic [PW-1:0]     pos_q, pos_n;
	logic [PW-1:0]     len_q, len_n;
	logic [BYTE_W-1:0] rxor_q, rxor_n;
	logic [BYTE_W-1:0] prefix_q [PREFIX_DEPTH];
	logic              pre_we;
	logic [PREFIX_AW-1:0] pre_addr;

	// Length recovered from prefix checksums: byte3 = p3^p2, byte4 = p4^p3
	logic [LEN_W-1:0]  len_hdr;
	logic [PW-1:0]     len_eff;
	logic [PW:0]       pos_inc;
	logic [BYTE_W-1:0] expect_b;
	result_t           res_n, res_q;

	assign len_hdr = {prefix_q[3] ^ prefix_q[2], prefix_q[4] ^ prefix_q[3]};
	assign len_eff = (pos_q == PW'(LEN_CHECK_POS)) ? PW'(len_hdr) : len_q;
	assign pos_inc = {1'b0, pos_q} + (PW+1)'(1);

	// Expected checksum for the closing byte
	always_comb begin
		expect_b = rxor_q;
		if (len_eff < PW'(7)) begin
			unique case (len_eff[2:0])
				3'd2:    expect_b = prefix_q[0];
				3'd3:    expect_b = prefix_q[1];
				3'd4:    expect_b = prefix_q[2];
				3'd5:    expect_b = prefix_q[3];
				3'd6:    expect_b = prefix_q[4];
				default: expect_b = '0;
			endcase
		end
	end

	// Next frame state and result
	always_comb begin
		phase_n  = phase_q;
		pos_n    = pos_q;
		len_n    = len_q;
		rxor_n   = rxor_q;
		pre_we   = 1'b0;
		pre_addr = '0;
		res_n.data_byte  = byte_s1;
		res_n.byte_index = '0;
		res_n.in_frame   = 1'b0;
		res_n.status     = ST_PROGRESS;
		unique case (phase_q)
			PH_SYNC1: begin
				res_n.byte_index = INDEX_W'(1);
				res_n.in_frame   = 1'b1;
				if (byte_s1 == sync_second_q) begin
					rxor_n   = rxor_q ^ byte_s1;
					pre_we   = 1'b1;
					pre_addr = PREFIX_AW'(1);
					pos_n    = PW'(2);
					phase_n  = PH_BODY;
				end else begin
					res_n.status = ST_BAD_SYNC;
					phase_n      = PH_HUNT;
					pos_n        = '0;
				end
			end
			PH_BODY: begin
				res_n.byte_index = INDEX_W'(pos_q);
				res_n.in_frame   = 1'b1;
				if (pos_q == PW'(LEN_CHECK_POS)) begin
					len_n = PW'(len_hdr);
				end
				priority if (pos_q == PW'(LEN_CHECK_POS) && len_hdr > MAX_LEN_C) begin
					res_n.status = ST_LEN_BIG;
					phase_n      = PH_HUNT;
					pos_n        = '0;
				end else if (len_eff != '0 && pos_inc >= {1'b0, len_eff}) begin
					res_n.status = (byte_s1 == expect_b) ? ST_FRAME_OK : ST_XOR_BAD;
					phase_n      = PH_HUNT;
					pos_n        = '0;
				end else begin
					rxor_n   = rxor_q ^ byte_s1;
					pre_we   = (pos_q < PW'(PREFIX_DEPTH));
					pre_addr = pos_q[PREFIX_AW-1:0];
					pos_n    = PW'(pos_inc);
					if (pos_q == LAST_POS) begin
						res_n.status = ST_OVERFLOW;
						phase_n      = PH_HUNT;
						pos_n        = '0;
					end
				end
			end
			default: begin
				phase_n = PH_HUNT;
				if (byte_s1 == sync_first_q) begin
					res_n.in_frame = 1'b1;
					len_n    = '0;
					rxor_n   = byte_s1;
					pre_we   = 1'b1;
					pre_addr = '0;
					pos_n    = PW'(1);
					phase_n  = PH_SYNC1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			pos_q   <= '0;
			len_q   <= '0;
			rxor_q  <= '0;
		end else if (adv) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			len_q   <= len_n;
			rxor_q  <= rxor_n;
		end
	end

	// Prefix checksum store, entries written before they are read
	always_ff @(posedge clk) begin
		if (adv && pre_we) begin
			prefix_q[pre_addr] <= rxor_n;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'(res_q);

	// Checks
	a_hunt_discard: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !res_q.in_frame) |->
			(res_q.status == ST_PROGRESS && res_q.byte_index == '0))
		else $error("discarded byte carries index or status");

	a_sync1_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SYNC1) |-> (pos_q == PW'(1)))
		else $error("second sync phase with wrong position");

	a_body_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY) |-> (pos_q >= PW'(2) && pos_q <= LAST_POS))
		else $error("body position out of range");

	a_end_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res_n.status != ST_PROGRESS) |=> (phase_q == PH_HUNT && pos_q == '0))
		else $error("frame end did not return to hunting");

	a_bad_sync_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_q.status == ST_BAD_SYNC) |-> (res_q.byte_index == INDEX_W'(1)))
		else $error("bad sync reported away from index 1");

endmodule
